// ----- sv/tlblff_pkg.sv -----
// ----------------------------------------------------------------------------
// tlblff_pkg
// shared constants for the fifo-fill tlb: request codes and field widths
// ----------------------------------------------------------------------------
package tlblff_pkg;

    localparam int ADDR_W = 32;
    localparam int DATE_W = 32;

    // request codes carried on the action port
    localparam logic ACTION_LOOKUP = 1'b0;
    localparam logic ACTION_FILL   = 1'b1;

endpackage

// ----- sv/tlblff_ram.sv -----
// ----------------------------------------------------------------------------
// tlblff_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module tlblff_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/tlb_lookup_fifo_fill_top.sv -----
// ----------------------------------------------------------------------------
// tlb_lookup_fifo_fill_top
// fully associative tlb with first-in first-out replacement
// ----------------------------------------------------------------------------
// a lookup scans the entries from entry 0, one ram read per entry scanned,
//   stopping at the first matching entry or after the last entry
// a fill with a free entry writes at once, with no scan; a fill into a full tlb
//   scans every entry for the oldest creation date and replaces that entry
// a new request may start in the cycle that done is high; done cannot stall
// reset clears the valid bits and the sequencer; entry contents stay unknown
// ----------------------------------------------------------------------------
module tlb_lookup_fifo_fill_top #(
    parameter int TLB_ENTRIES      = 8,
    parameter int PAGE_OFFSET_BITS = 12
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        action,
    input  logic [31:0] virtual_address,
    input  logic [31:0] fill_physical_address,
    input  logic [31:0] request_date,
    output logic        done,
    output logic        hit,
    output logic [31:0] physical_address
);

    localparam int ADDR_W  = tlblff_pkg::ADDR_W;
    localparam int DATE_W  = tlblff_pkg::DATE_W;
    localparam int PAGE_W  = ADDR_W - PAGE_OFFSET_BITS;
    localparam int IDX_W   = $clog2(TLB_ENTRIES);
    localparam int ENTRY_W = 2 * PAGE_W + DATE_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TLB_ENTRIES - 1);

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    // sequencer and result registers
    state_t                     state_reg, state_next;
    logic [IDX_W-1:0]           idx_reg, idx_next;
    logic [IDX_W-1:0]           tgt_reg, tgt_next;
    logic [DATE_W-1:0]          min_reg, min_next;
    logic [TLB_ENTRIES-1:0]     valid_reg, valid_next;
    logic                       done_reg, done_next;
    logic                       hit_reg, hit_next;
    logic [ADDR_W-1:0]          pa_reg, pa_next;

    // request held for the duration of a scan
    logic                       act_reg;
    logic [PAGE_W-1:0]          page_reg;
    logic [PAGE_W-1:0]          frame_reg;
    logic [PAGE_OFFSET_BITS-1:0] offset_reg;
    logic [DATE_W-1:0]          date_reg;

    // entry store: {page, frame, created} per entry
    logic                       ram_we;
    logic [IDX_W-1:0]           ram_waddr;
    logic [ENTRY_W-1:0]         ram_wdata;
    logic [IDX_W-1:0]           ram_raddr;
    logic [ENTRY_W-1:0]         ram_rdata;

    logic [PAGE_W-1:0]          rd_page;
    logic [PAGE_W-1:0]          rd_frame;
    logic [DATE_W-1:0]          rd_created;

    logic                       has_free;
    logic [IDX_W-1:0]           free_idx;
    logic                       older;
    logic [IDX_W-1:0]           sel_tgt;
    logic                       accept;

    tlblff_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TLB_ENTRIES)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_page    = ram_rdata[ENTRY_W-1 -: PAGE_W];
    assign rd_frame   = ram_rdata[DATE_W +: PAGE_W];
    assign rd_created = ram_rdata[DATE_W-1:0];

    assign accept = start && !busy;

    // first invalid entry, lowest index wins
    assign has_free = ~&valid_reg;

    always_comb
    begin
        free_idx = '0;
        for (int i = TLB_ENTRIES - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_idx = IDX_W'(i);
            end
        end
    end

    // oldest-entry tracking: entry 0 seeds, strict less keeps the lowest index on ties
    assign older   = (idx_reg == '0) || (rd_created < min_reg);
    assign sel_tgt = older ? idx_reg : tgt_reg;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        tgt_next   = tgt_reg;
        min_next   = min_reg;
        valid_next = valid_reg;
        done_next  = 1'b0;
        hit_next   = 1'b0;
        pa_next    = '0;
        ram_we     = 1'b0;
        ram_waddr  = free_idx;
        ram_wdata  = {page_reg, frame_reg, date_reg};
        ram_raddr  = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                // entry 0 is read here so its data meets the first scan cycle
                if (accept)
                begin
                    idx_next = '0;
                    if (action == tlblff_pkg::ACTION_FILL && has_free)
                    begin
                        // free slot known at once: write straight from the ports
                        ram_we     = 1'b1;
                        ram_waddr  = free_idx;
                        ram_wdata  = {virtual_address[ADDR_W-1 -: PAGE_W],
                                      fill_physical_address[ADDR_W-1 -: PAGE_W],
                                      request_date};
                        valid_next[free_idx] = 1'b1;
                        done_next  = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                // read ahead to the next entry; the wrap after the last is harmless
                ram_raddr = idx_reg + IDX_W'(1);
                if (act_reg == tlblff_pkg::ACTION_LOOKUP)
                begin
                    if (valid_reg[idx_reg] && rd_page == page_reg)
                    begin
                        done_next  = 1'b1;
                        hit_next   = 1'b1;
                        pa_next    = {rd_frame, offset_reg};
                        state_next = ST_IDLE;
                    end
                    else if (idx_reg == LAST_IDX)
                    begin
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
                else
                begin
                    // full tlb: every entry is valid, look for the oldest
                    if (older)
                    begin
                        min_next = rd_created;
                        tgt_next = idx_reg;
                    end
                    if (idx_reg == LAST_IDX)
                    begin
                        ram_we     = 1'b1;
                        ram_waddr  = sel_tgt;
                        valid_next[sel_tgt] = 1'b1;
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            tgt_reg   <= '0;
            min_reg   <= '0;
            valid_reg <= '0;
            done_reg  <= 1'b0;
            hit_reg   <= 1'b0;
            pa_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            tgt_reg   <= tgt_next;
            min_reg   <= min_next;
            valid_reg <= valid_next;
            done_reg  <= done_next;
            hit_reg   <= hit_next;
            pa_reg    <= pa_next;
        end
    end

    // request capture on every accepted transfer
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg    <= action;
            page_reg   <= virtual_address[ADDR_W-1 -: PAGE_W];
            frame_reg  <= fill_physical_address[ADDR_W-1 -: PAGE_W];
            offset_reg <= virtual_address[PAGE_OFFSET_BITS-1:0];
            date_reg   <= request_date;
        end
    end

    assign busy             = (state_reg != ST_IDLE);
    assign done             = done_reg;
    assign hit              = hit_reg;
    assign physical_address = pa_reg;

endmodule

// ----- sv/tlblff_checker.sv -----
// ----------------------------------------------------------------------------
// tlblff_checker
// port-level checks on the tlb sequencer, bound to the top level
// ----------------------------------------------------------------------------
module tlblff_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        action,
    input logic        done,
    input logic        hit,
    input logic [31:0] physical_address
);

    // a result transfer only appears once the sequencer has let go
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result transfer while busy");

    // an accepted request either completes at once or starts a scan
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> (done || busy))
        else $error("accepted request dropped");

    // a scan runs until it produces a result
    assert property (@(posedge clk) disable iff (!rst_n) busy |=> (busy || done))
        else $error("scan ended without a result");

    // misses and fills answer zero
    assert property (@(posedge clk) disable iff (!rst_n)
                     (done && !hit) |-> (physical_address == 32'd0))
        else $error("non-zero address without hit");

    // no hit follows directly on an accepted fill
    assert property (@(posedge clk) disable iff (!rst_n)
                     (start && !busy && action == tlblff_pkg::ACTION_FILL) |=> !hit)
        else $error("fill reported a hit");

endmodule

bind tlb_lookup_fifo_fill_top tlblff_checker u_tlblff_checker (.*);
